FILE: design/bpa_pkg.sv
package bpa_pkg;

  localparam int PageCount  = 4096;
  localparam int OrderCount = 11;
  localparam int TopOrder   = OrderCount - 1;
  localparam int PageW      = $clog2(PageCount);
  localparam int LinkW      = PageW + 1;
  localparam int OrderW     = $clog2(OrderCount);
  localparam int FreeW      = PageW + 1;
  localparam int MaxBlocks  = PageCount / (1 << TopOrder);
  localparam int PoolReset  = (MaxBlocks < 4) ? MaxBlocks : 4;

  localparam logic [LinkW-1:0] Nil      = LinkW'(PageCount);
  localparam logic [LinkW-1:0] TopPages = LinkW'(1 << TopOrder);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoBlock  = 2'd1,
    StBadFree  = 2'd2
  } status_e;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // One page entry: free, root, order and both list links.
  typedef struct packed {
    logic              free;
    logic              root;
    logic [OrderW-1:0] order;
    logic [LinkW-1:0]  next;
    logic [LinkW-1:0]  prev;
  } page_ent_t;

endpackage

FILE: design/buddy_page_allocator_unit.sv
// An allocate searches the free lists upward from the requested order and splits the
// block it finds down to that order; a free merges the block with each free buddy of
// equal order up to the top order. An out-of-range allocate order gives StNoBlock.
// One request at a time: the next word is taken once the result is read.
// Reset and every cfg_we_i write start a clearing pass over all PageCount (4096) page
// entries, during which no word is taken.
module buddy_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_order[3:0], page_index[15:4]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // status[1:0], block_index[13:2], block_order[17:14],
                                      // free_pages[30:18]
);

  typedef enum logic [4:0] {
    SClear, SIdle, SFind, SOut,
    AHeadRd, AHeadChk, ASplit, AFin,
    FRd, FChk, FLoop, FBudRd, FBudChk, FPrRd, FPrW, FBudW, FIdxW, FPushSel,
    NRd, NW, PushRd, PushH, PushW
  } state_e;

  state_e                   state_q;
  page_ent_t                mem [PageCount];
  page_ent_t                rd_q;
  logic                     we;
  logic [PageW-1:0]         waddr, raddr;
  page_ent_t                wdata;
  logic                     re;

  logic [2:0]               pool_q;
  logic [PageW-1:0]         clr_q;
  logic [LinkW-1:0]         head_q [OrderCount];
  logic                     cmd_q;
  logic [OrderW-1:0]        req_q, cur_q;
  logic [PageW-1:0]         idx_q, bud_q, q_q, p_q;
  logic [LinkW-1:0]         n_q, pr_q;
  status_e                  st_q;
  logic [PageW-1:0]         bidx_q;
  logic [OrderW-1:0]        bord_q;
  logic [FreeW-1:0]         free_q;
  logic [2:0]               pool_sat;
  logic [LinkW-1:0]         pool_pages;
  logic [OrderW-1:0]        cur_dn;
  logic [FreeW-1:0]         ord_pages;
  logic [PageW-1:0]         ord_bit, split_bit;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  assign pool_sat   = (32'(cfg_wdata_i) > MaxBlocks) ? 3'(MaxBlocks) : cfg_wdata_i;
  assign pool_pages = LinkW'(pool_q) << TopOrder;
  assign cur_dn     = cur_q - 1'b1;
  assign ord_pages  = FreeW'(1) << cur_q;
  assign ord_bit    = PageW'(1) << cur_q;
  assign split_bit  = PageW'(1) << cur_dn;

  assign s_axis_tready = (state_q == SIdle) && !m_axis_tvalid;
  assign m_axis_tdata  = {1'b0, free_q, bord_q, bidx_q, st_q};

  // Memory port control: at most one read or one write per cycle, chosen by state.
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    unique case (state_q)
      SClear: begin
        we = 1'b1; waddr = clr_q;
        wdata.free = {1'b0, clr_q} < pool_pages;
        wdata.root = wdata.free && (clr_q[TopOrder-1:0] == '0);
        wdata.order = wdata.root ? OrderW'(TopOrder) : '0;
        wdata.next = Nil; wdata.prev = Nil;
        if (wdata.root) begin
          wdata.prev = (clr_q[PageW-1:TopOrder] == '0) ? Nil : {1'b0, clr_q} - TopPages;
          wdata.next = ({1'b0, clr_q} + TopPages < pool_pages) ?
                       {1'b0, clr_q} + TopPages : Nil;
        end
      end
      AHeadRd: begin re = 1'b1; raddr = p_q; end
      FRd: begin re = 1'b1; raddr = idx_q; end
      FBudRd: begin re = 1'b1; raddr = bud_q; end
      FPrRd: begin re = 1'b1; raddr = pr_q[PageW-1:0]; end
      FPrW: begin
        we = 1'b1; waddr = pr_q[PageW-1:0]; wdata = rd_q; wdata.next = n_q;
      end
      NRd: begin re = 1'b1; raddr = n_q[PageW-1:0]; end
      NW: begin
        we = 1'b1; waddr = n_q[PageW-1:0]; wdata = rd_q; wdata.prev = pr_q;
      end
      PushRd: begin re = 1'b1; raddr = head_q[cur_q][PageW-1:0]; end
      PushH: begin
        we = 1'b1; waddr = head_q[cur_q][PageW-1:0]; wdata = rd_q;
        wdata.prev = {1'b0, q_q};
      end
      PushW: begin
        we = 1'b1; waddr = q_q; wdata = {1'b1, 1'b1, cur_q, head_q[cur_q], Nil};
      end
      AFin: begin we = 1'b1; waddr = p_q; wdata = {1'b0, 1'b1, req_q, Nil, Nil}; end
      FBudW: begin we = 1'b1; waddr = bud_q; wdata = {1'b1, 1'b0, cur_q, Nil, Nil}; end
      FIdxW: begin we = 1'b1; waddr = idx_q; wdata = {1'b1, 1'b0, cur_q, Nil, Nil}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; pool_q <= 3'(PoolReset); clr_q <= '0;
      m_axis_tvalid <= 1'b0;
      for (int o = 0; o < OrderCount; o++) begin
        head_q[o] <= (o == TopOrder && PoolReset > 0) ? '0 : Nil;
      end
      free_q <= FreeW'(PoolReset) << TopOrder;
      cmd_q <= CmdAlloc; req_q <= '0; cur_q <= '0;
      idx_q <= '0; bud_q <= '0; q_q <= '0; p_q <= '0; n_q <= Nil; pr_q <= Nil;
      st_q <= StOk; bidx_q <= '0; bord_q <= '0;
    end else if (cfg_we_i) begin
      pool_q <= pool_sat; clr_q <= '0; state_q <= SClear;
      m_axis_tvalid <= 1'b0;
      for (int o = 0; o < OrderCount; o++) begin
        head_q[o] <= (o == TopOrder && pool_sat != '0) ? '0 : Nil;
      end
      free_q <= FreeW'(pool_sat) << TopOrder;
    end else begin
      if (state_q == SOut) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == PageW'(PageCount - 1)) state_q <= SIdle;
        end
        SIdle: if (s_axis_tvalid && s_axis_tready) begin
          cmd_q <= s_axis_tuser; req_q <= s_axis_tdata[3:0];
          cur_q <= s_axis_tdata[3:0]; idx_q <= s_axis_tdata[15:4];
          st_q <= StOk; bidx_q <= '0; bord_q <= '0;
          if (s_axis_tuser == CmdAlloc) state_q <= SFind;
          else state_q <= FRd;
        end
        SFind: begin
          if (32'(cur_q) >= OrderCount) begin st_q <= StNoBlock; state_q <= SOut; end
          else if (head_q[cur_q] != Nil) begin
            p_q <= head_q[cur_q][PageW-1:0]; state_q <= AHeadRd;
          end else cur_q <= cur_q + 1'b1;
        end
        AHeadRd: state_q <= AHeadChk;
        // The allocated block is always the list head, so only its successor needs a fix.
        AHeadChk: begin
          head_q[cur_q] <= rd_q.next;
          n_q <= rd_q.next; pr_q <= Nil;
          free_q <= free_q - ord_pages;
          state_q <= (rd_q.next != Nil) ? NRd : ASplit;
        end
        ASplit: begin
          if (cur_q > req_q) begin
            cur_q <= cur_dn; q_q <= p_q | split_bit;
            state_q <= (head_q[cur_dn] != Nil) ? PushRd : PushW;
          end else state_q <= AFin;
        end
        AFin: begin bidx_q <= p_q; bord_q <= req_q; state_q <= SOut; end
        FRd: state_q <= FChk;
        FChk: begin
          if (rd_q.free || !rd_q.root) begin st_q <= StBadFree; state_q <= SOut; end
          else begin cur_q <= rd_q.order; state_q <= FLoop; end
        end
        FLoop: begin
          if (32'(cur_q) < TopOrder) begin bud_q <= idx_q ^ ord_bit; state_q <= FBudRd; end
          else state_q <= FPushSel;
        end
        FBudRd: state_q <= FBudChk;
        FBudChk: begin
          if (!rd_q.free || !rd_q.root || rd_q.order != cur_q) state_q <= FPushSel;
          else begin
            n_q <= rd_q.next; pr_q <= rd_q.prev;
            free_q <= free_q - ord_pages;
            if (rd_q.prev != Nil) state_q <= FPrRd;
            else begin
              head_q[cur_q] <= rd_q.next;
              state_q <= (rd_q.next != Nil) ? NRd : FBudW;
            end
          end
        end
        FPrRd: state_q <= FPrW;
        FPrW: state_q <= (n_q != Nil) ? NRd : FBudW;
        NRd: state_q <= NW;
        NW: state_q <= (cmd_q == CmdAlloc) ? ASplit : FBudW;
        FBudW: state_q <= FIdxW;
        FIdxW: begin
          idx_q <= idx_q & bud_q; cur_q <= cur_q + 1'b1; state_q <= FLoop;
        end
        FPushSel: begin
          q_q <= idx_q; bidx_q <= idx_q; bord_q <= cur_q;
          state_q <= (head_q[cur_q] != Nil) ? PushRd : PushW;
        end
        PushRd: state_q <= PushH;
        PushH: state_q <= PushW;
        PushW: begin
          head_q[cur_q] <= {1'b0, q_q};
          free_q <= free_q + ord_pages;
          state_q <= (cmd_q == CmdAlloc) ? ASplit : SOut;
        end
        SOut: state_q <= SIdle;
      endcase
    end
  end

endmodule

FILE: dv/buddy_page_allocator_unit_test.sv
module buddy_page_allocator_unit_test
  import bpa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_e     status;
    logic [11:0] block_index;
    logic [3:0]  block_order;
    logic [12:0] free_pages;
  } alloc_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  // Shadow page table and free lists.
  bit          pg_free [PageCount];
  bit          pg_root [PageCount];
  int          pg_order[PageCount];
  int          pg_next [PageCount];
  int          pg_prev [PageCount];
  int          head    [OrderCount];
  int          nblocks [OrderCount];

  alloc_reply_t reply_q[$];
  int           live_roots[$];
  int           n_errors;
  bit           idle_en;
  int           hold_cycles;

  buddy_page_allocator_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void list_push(int o, int p);
    int h;
    h = head[o];
    pg_next[p] = h;
    pg_prev[p] = PageCount;
    if (h < PageCount) pg_prev[h] = p;
    head[o] = p;
    nblocks[o]++;
  endfunction

  function automatic void list_unlink(int o, int p);
    int n;
    int pr;
    n = pg_next[p];
    pr = pg_prev[p];
    if (pr < PageCount) pg_next[pr] = n;
    else head[o] = n;
    if (n < PageCount) pg_prev[n] = pr;
    pg_next[p] = PageCount;
    pg_prev[p] = PageCount;
    if (nblocks[o] > 0) nblocks[o]--;
  endfunction

  function automatic void rebuild_pool(int nb);
    int pool_pages;
    if (nb > MaxBlocks) nb = MaxBlocks;
    pool_pages = nb << TopOrder;
    for (int b = 0; b < PageCount; b++) begin
      pg_free[b] = (b < pool_pages);
      pg_root[b] = 0;
      pg_order[b] = 0;
      pg_next[b] = PageCount;
      pg_prev[b] = PageCount;
    end
    for (int o = 0; o < OrderCount; o++) begin
      head[o] = PageCount;
      nblocks[o] = 0;
    end
    for (int b = nb; b > 0; b--) begin
      pg_root[(b - 1) << TopOrder] = 1;
      pg_order[(b - 1) << TopOrder] = TopOrder;
      list_push(TopOrder, (b - 1) << TopOrder);
    end
    live_roots.delete();
  endfunction

  function automatic alloc_reply_t predict_request(bit cmd, int req, int pg);
    alloc_reply_t r;
    int cur;
    int p;
    int idx;
    int ord;
    int bud;
    int total;
    r.status = StOk;
    r.block_index = '0;
    r.block_order = '0;
    if (cmd == CmdAlloc) begin
      cur = req;
      while (cur < OrderCount && head[cur] >= PageCount) cur++;
      if (cur >= OrderCount) begin
        r.status = StNoBlock;
      end else begin
        p = head[cur];
        list_unlink(cur, p);
        pg_free[p] = 0;
        pg_root[p] = 1;
        while (cur > req) begin
          cur--;
          pg_order[p + (1 << cur)] = cur;
          pg_root[p + (1 << cur)] = 1;
          pg_free[p + (1 << cur)] = 1;
          list_push(cur, p + (1 << cur));
        end
        pg_order[p] = req;
        r.block_index = 12'(p);
        r.block_order = 4'(req);
        live_roots.push_back(p);
      end
    end else if (pg_free[pg] || !pg_root[pg]) begin
      r.status = StBadFree;
    end else begin
      idx = pg;
      ord = pg_order[pg];
      pg_free[pg] = 1;
      while (ord < TopOrder) begin
        bud = idx ^ (1 << ord);
        if (!pg_free[bud] || !pg_root[bud] || pg_order[bud] != ord) break;
        list_unlink(ord, bud);
        pg_root[bud] = 0;
        pg_root[idx] = 0;
        idx &= bud;
        ord++;
      end
      pg_root[idx] = 1;
      pg_free[idx] = 1;
      pg_order[idx] = ord;
      list_push(ord, idx);
      r.block_index = 12'(idx);
      r.block_order = 4'(ord);
      foreach (live_roots[i]) begin
        if (live_roots[i] == pg) begin
          live_roots.delete(i);
          break;
        end
      end
    end
    total = 0;
    for (int o = 0; o < OrderCount; o++) total += nblocks[o] << o;
    r.free_pages = 13'(total);
    return r;
  endfunction

  task automatic send_request(bit cmd, int req, int pg);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {pg[11:0], req[3:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    reply_q.push_back(predict_request(cmd, req, pg));
  endtask

  task automatic drain_and_write_pool(int value);
    s_axis_tvalid <= 1'b0;
    wait (reply_q.size() == 0);
    // A request may still be finishing inside the sequencer.
    repeat (100) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value[2:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rebuild_pool(value);
  endtask

  task automatic free_random_live();
    int k;
    k = $urandom_range(0, live_roots.size() - 1);
    send_request(CmdFree, $urandom_range(0, 15), live_roots[k]);
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_request(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                   $urandom_range(0, 4095));
    end else if (pick < 50 && live_roots.size() > 0) begin
      free_random_live();
    end else if (pick < 56) begin
      send_request(CmdAlloc, $urandom_range(0, 10), $urandom_range(0, 4095));
    end else begin
      send_request(CmdAlloc, $urandom_range(0, 4), $urandom_range(0, 4095));
    end
  endtask

  task automatic test_directed();
    send_request(CmdAlloc, 0, 12'hfff);
    send_request(CmdAlloc, 10, 0);
    send_request(CmdAlloc, 11, 0);
    send_request(CmdAlloc, 15, 0);
    send_request(CmdFree, 0, 1);
    send_request(CmdFree, 15, 4095);
    send_request(CmdFree, 0, 1024);
    send_request(CmdFree, 0, 0);
    send_request(CmdFree, 0, 0);
    send_request(CmdAlloc, 9, 0);
    send_request(CmdAlloc, 9, 0);
    send_request(CmdAlloc, 3, 0);
    send_request(CmdFree, 0, 512);
    send_request(CmdFree, 0, 0);
    send_request(CmdFree, 0, 1024);
    for (int i = 0; i < 5; i++) send_request(CmdAlloc, 10, 0);
  endtask

  task automatic test_pool_sizes();
    drain_and_write_pool(0);
    send_request(CmdAlloc, 0, 0);
    send_request(CmdFree, 0, 0);
    drain_and_write_pool(1);
    send_request(CmdAlloc, 1, 0);
    send_request(CmdFree, 0, 2048);
    send_request(CmdFree, 0, 0);
    drain_and_write_pool(7);
    send_request(CmdAlloc, 10, 0);
    send_request(CmdFree, 0, 3072);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_request(CmdAlloc, $urandom_range(0, 3), 0);
  endtask

  task automatic test_random(int count, int pool);
    drain_and_write_pool(pool);
    for (int i = 0; i < count; i++) random_request();
  endtask

  // Receiver side: random stalls, or one long hold requested by a test.
  initial begin
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    alloc_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reply_q.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata);
        n_errors++;
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          n_errors++;
        end
        if (m_axis_tdata[13:2] !== want.block_index) begin
          $error("block_index: expected %0d, got %0d", want.block_index,
                 m_axis_tdata[13:2]);
          n_errors++;
        end
        if (m_axis_tdata[17:14] !== want.block_order) begin
          $error("block_order: expected %0d, got %0d", want.block_order,
                 m_axis_tdata[17:14]);
          n_errors++;
        end
        if (m_axis_tdata[30:18] !== want.free_pages) begin
          $error("free_pages: expected %0d, got %0d", want.free_pages,
                 m_axis_tdata[30:18]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    n_errors = 0;
    hold_cycles = 0;
    idle_en = 1'b1;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    rebuild_pool(4);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_pool_sizes();
    test_random(400, 4);
    test_backpressure();
    test_random(250, 2);
    test_random(200, 3);
    test_random(250, 5);
    idle_en = 1'b0;
    test_random(250, 4);

    s_axis_tvalid <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
